// ----- hw/rtl/wpp_pkg.sv -----
package wpp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_CONTAINER    = 3'd1,
    ERR_NOT_PCM      = 3'd2,
    ERR_CHANNELS     = 3'd3,
    ERR_INCONSISTENT = 3'd4,
    ERR_DEPTH        = 3'd5,
    ERR_ORDER        = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SIZE    = 2'd1,
    PH_SAMPLES = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [23:0] sample_value;
    logic               channel;
    err_e               error_code;
    logic [1:0]         num_channels;
    logic [31:0]        rate_hz;
    logic [4:0]         bits_per_sample;
    logic               last_of_run;
  } out_t;

  // one queue entry: a result word, optionally followed by end of stream
  typedef struct packed {
    out_t first;
    logic then_end;
  } entry_t;

  localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
  localparam logic [23:0] TAG_FMT     = 24'h66_6D74;
  localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
  localparam logic [31:0] RATE_RESET  = 32'd44100;
  localparam logic [15:0] DEPTH_RESET = 16'd16;

endpackage

// ----- hw/rtl/wpp_front.sv -----
module wpp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  wpp_pkg::in_t  in_data_i,
  output logic          push_o,
  output wpp_pkg::entry_t entry_o
);
  import wpp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d, tag_q, tag_d, foff_q, foff_d, doff_q, doff_d;
  logic        ffound_q, ffound_d;
  logic [15:0] fc_q, fc_d, chn_q, chn_d, align_q, align_d, dep_q, dep_d;
  logic [31:0] rate_q, rate_d, brate_q, brate_d, left_q, left_d;
  logic [1:0]  r3_q, r3_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  bis_q, bis_d;
  logic        cch_q, cch_d;
  logic [47:0] prod_q;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] frel, drel, left_new;
  logic [15:0] bps, align_exp;
  logic [48:0] exp_full;
  logic [45:0] expect_rate;
  logic [2:0]  rem;
  logic [1:0]  rem3, nbis;
  err_e        verr;
  entry_t      e;

  function automatic logic [1:0] mod3(input logic [7:0] v, input logic [1:0] a);
    logic [3:0] s;
    s = {2'b0, v[1:0]} + {2'b0, v[3:2]} + {2'b0, v[5:4]} + {2'b0, v[7:6]} + {2'b0, a};
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12:  mod3 = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13: mod3 = 2'd1;
      default:                        mod3 = 2'd2;
    endcase
  endfunction

  always_ff @(posedge clk_i) begin
    prod_q <= rate_q * dep_q;
  end

  always_comb begin
    b = in_data_i.data_byte;
    eof = in_data_i.end_of_file;
    phase_d = phase_q; pos_d = pos_q; tag_d = tag_q; foff_d = foff_q; doff_d = doff_q;
    ffound_d = ffound_q; fc_d = fc_q; chn_d = chn_q; align_d = align_q; dep_d = dep_q;
    rate_d = rate_q; brate_d = brate_q; left_d = left_q; r3_d = r3_q;
    acc_d = acc_q; bis_d = bis_q; cch_d = cch_q;
    e = '0;
    e.first.kind = KIND_END;
    e.first.error_code = ERR_NONE;
    push_o = 1'b0;
    frel = pos_q - foff_q;
    drel = pos_q - doff_q;
    bps = dep_q >> 3;
    align_exp = (chn_q == 16'd2) ? {bps[14:0], 1'b0} : bps;
    exp_full = (chn_q == 16'd2) ? {prod_q, 1'b0} : {1'b0, prod_q};
    expect_rate = exp_full[48:3];
    verr = ERR_NONE;
    rem = 3'd0;
    rem3 = 2'd0;
    left_new = '0;
    nbis = bis_q + 2'd1;

    if (accept_i) begin
      if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;
      case (phase_q)
        PH_HEADER: begin
          tag_d = {tag_q[23:0], b};
          if ((pos_q == 32'd3 && tag_d != TAG_RIFF) ||
              (pos_q == 32'd11 && tag_d != TAG_WAVE)) begin
            push_o = 1'b1;
            e.first.kind = KIND_ERROR;
            e.first.error_code = ERR_CONTAINER;
            phase_d = PH_HALT;
          end else begin
            if (ffound_q) begin
              if (frel[31:5] == '0 && frel[4:0] >= 5'd8) begin
                case (frel[4:0])
                  5'd8:  fc_d = {8'h0, b};
                  5'd9:  fc_d = fc_q | {b, 8'h0};
                  5'd10: chn_d = {8'h0, b};
                  5'd11: chn_d = chn_q | {b, 8'h0};
                  5'd12: rate_d = {24'h0, b};
                  5'd13: rate_d = rate_q | {16'h0, b, 8'h0};
                  5'd14: rate_d = rate_q | {8'h0, b, 16'h0};
                  5'd15: rate_d = rate_q | {b, 24'h0};
                  5'd16: brate_d = {24'h0, b};
                  5'd17: brate_d = brate_q | {16'h0, b, 8'h0};
                  5'd18: brate_d = brate_q | {8'h0, b, 16'h0};
                  5'd19: brate_d = brate_q | {b, 24'h0};
                  5'd20: align_d = {8'h0, b};
                  5'd21: align_d = align_q | {b, 8'h0};
                  5'd22: dep_d = {8'h0, b};
                  5'd23: dep_d = dep_q | {b, 8'h0};
                  default: ;
                endcase
              end
            end else if (pos_q >= 32'd2 && tag_d[23:0] == TAG_FMT) begin
              ffound_d = 1'b1;
              foff_d = pos_q - 32'd2;
            end
            if (eof) begin
              push_o = 1'b1;
              e.first.kind = KIND_ERROR;
              e.first.error_code = ERR_CONTAINER;
              phase_d = PH_HALT;
            end else if (pos_q >= 32'd3 && tag_d == TAG_DATA) begin
              doff_d = pos_q - 32'd3;
              if (!ffound_q || frel <= 32'd23) begin
                push_o = 1'b1;
                e.first.kind = KIND_ERROR;
                e.first.error_code = ERR_ORDER;
                phase_d = PH_HALT;
              end else begin
                phase_d = PH_SIZE;
              end
            end
          end
        end
        PH_SIZE: begin
          // running residue mod 3 of the size, since 256 is 1 mod 3
          case (drel)
            32'd4: begin left_d = {24'h0, b}; r3_d = mod3(b, 2'd0); end
            32'd5: begin left_d = left_q | {16'h0, b, 8'h0}; r3_d = mod3(b, r3_q); end
            32'd6: begin left_d = left_q | {8'h0, b, 16'h0}; r3_d = mod3(b, r3_q); end
            32'd7: begin left_d = left_q | {b, 24'h0}; r3_d = mod3(b, r3_q); end
            default: ;
          endcase
          if (drel == 32'd7) begin
            if (fc_q != 16'd1) verr = ERR_NOT_PCM;
            else if (chn_q < 16'd1 || chn_q > 16'd2) verr = ERR_CHANNELS;
            else if ({14'h0, brate_q} != expect_rate || align_q != align_exp)
              verr = ERR_INCONSISTENT;
            else if (dep_q != 16'd8 && dep_q != 16'd16 && dep_q != 16'd24) verr = ERR_DEPTH;
            push_o = 1'b1;
            if (verr != ERR_NONE) begin
              e.first.kind = KIND_ERROR;
              e.first.error_code = verr;
              phase_d = PH_HALT;
            end else begin
              e.first.kind = KIND_FORMAT;
              e.first.num_channels = chn_q[1:0];
              e.first.rate_hz = rate_q;
              e.first.bits_per_sample = dep_q[4:0];
              rem3 = r3_d;
              // drop the tail that is not a whole frame
              case ({chn_q[1], bps[1:0]})
                3'b0_01: rem = 3'd0;
                3'b0_10: rem = {2'b0, left_d[0]};
                3'b0_11: rem = {1'b0, rem3};
                3'b1_01: rem = {2'b0, left_d[0]};
                3'b1_10: rem = {1'b0, left_d[1:0]};
                default: begin
                  case ({left_d[0], rem3})
                    3'b0_00: rem = 3'd0;
                    3'b1_01: rem = 3'd1;
                    3'b0_10: rem = 3'd2;
                    3'b1_00: rem = 3'd3;
                    3'b0_01: rem = 3'd4;
                    default: rem = 3'd5;
                  endcase
                end
              endcase
              left_new = left_d - {29'h0, rem};
              left_d = left_new;
              if (left_new == '0 || eof) begin
                e.then_end = 1'b1;
                phase_d = PH_HALT;
              end else begin
                phase_d = PH_SAMPLES;
                acc_d = '0;
                bis_d = '0;
                cch_d = 1'b0;
              end
            end
          end else if (eof) begin
            push_o = 1'b1;
            e.first.kind = KIND_ERROR;
            e.first.error_code = ERR_CONTAINER;
            phase_d = PH_HALT;
          end
        end
        PH_SAMPLES: begin
          case (bis_q)
            2'd0:    acc_d = acc_q | {16'h0, b};
            2'd1:    acc_d = acc_q | {8'h0, b, 8'h0};
            default: acc_d = acc_q | {b, 16'h0};
          endcase
          bis_d = nbis;
          left_d = left_q - 32'd1;
          if ({14'h0, nbis} >= bps) begin
            push_o = 1'b1;
            e.first.kind = KIND_SAMPLE;
            e.first.channel = cch_q;
            case (bps[1:0])
              2'd1:    e.first.sample_value = {~acc_d[7], acc_d[6:0], 16'h0};
              2'd2:    e.first.sample_value = {acc_d[15:0], 8'h0};
              default: e.first.sample_value = acc_d;
            endcase
            acc_d = '0;
            bis_d = '0;
            if (chn_q == 16'd2) cch_d = ~cch_q;
          end
          if (left_d == '0 || eof) begin
            if (push_o) begin
              e.then_end = 1'b1;
            end else begin
              push_o = 1'b1;
              e.first.kind = KIND_END;
            end
            phase_d = PH_HALT;
          end
        end
        default: ;
      endcase
      e.first.last_of_run = ~e.then_end;
      if (eof) begin
        phase_d = PH_HEADER; pos_d = '0; tag_d = '0; foff_d = '0; doff_d = '0;
        ffound_d = 1'b0; fc_d = '0; chn_d = '0; align_d = '0; dep_d = DEPTH_RESET;
        rate_d = RATE_RESET; brate_d = '0; left_d = '0; r3_d = '0;
        acc_d = '0; bis_d = '0; cch_d = 1'b0;
      end
    end
    entry_o = e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= '0; tag_q <= '0; foff_q <= '0; doff_q <= '0;
      ffound_q <= 1'b0; fc_q <= '0; chn_q <= '0; align_q <= '0; dep_q <= DEPTH_RESET;
      rate_q <= RATE_RESET; brate_q <= '0; left_q <= '0; r3_q <= '0;
      acc_q <= '0; bis_q <= '0; cch_q <= 1'b0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; tag_q <= tag_d; foff_q <= foff_d;
      doff_q <= doff_d; ffound_q <= ffound_d; fc_q <= fc_d; chn_q <= chn_d;
      align_q <= align_d; dep_q <= dep_d; rate_q <= rate_d; brate_q <= brate_d;
      left_q <= left_d; r3_q <= r3_d; acc_q <= acc_d; bis_q <= bis_d; cch_q <= cch_d;
    end
  end

endmodule

// ----- hw/rtl/wpp_fifo.sv -----
module wpp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wpp_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output wpp_pkg::entry_t rdata_o,
  output logic            empty_o
);
  import wpp_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ----- hw/rtl/wpp_back.sv -----
module wpp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  wpp_pkg::entry_t rdata_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wpp_pkg::out_t   out_data_o
);
  import wpp_pkg::*;

  logic valid_q, pend_q;
  out_t data_q;
  out_t end_word;
  logic load;

  assign load = !valid_q || out_ready_i;
  assign pop_o = load && !pend_q && !empty_i;
  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

  always_comb begin
    end_word = '0;
    end_word.kind = KIND_END;
    end_word.error_code = ERR_NONE;
    end_word.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= pend_q ? end_word : rdata_i.first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        pend_q  <= !empty_i && rdata_i.then_end;
      end
    end
  end

endmodule

// ----- hw/rtl/wav_pcm_stream_parser_unit.sv -----
// a word's first result is written into the queue and from there into the output register
// throughput: one byte per cycle while the queue is not full; a byte with two results gives two output words
// the input stalls only when the two-entry queue before the output stage is full
// validation multiply is a registered 32x16 product, ready long before the size ends
// reset (rst_ni low, asynchronous) clears the parser to its header state and empties the queue
module wav_pcm_stream_parser_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wpp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wpp_pkg::out_t  out_data_o
);
  import wpp_pkg::*;

  logic   push, full, pop, empty;
  entry_t wdata, rdata;

  assign in_ready_o = !full;

  wpp_front u_front (
    .clk_i, .rst_ni,
    .accept_i (in_valid_i && !full),
    .in_data_i,
    .push_o   (push),
    .entry_o  (wdata)
  );

  wpp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  wpp_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .rdata_i (rdata),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ----- hw/rtl/wpp_checker.sv -----
module wpp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input wpp_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input wpp_pkg::out_t out_data_o
);
  import wpp_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_ERROR || out_data_o.kind == KIND_END)
    |-> out_data_o.last_of_run)
    else $error("error or end not last of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_FORMAT |->
    (out_data_o.num_channels == 2'd1 || out_data_o.num_channels == 2'd2) &&
    (out_data_o.bits_per_sample == 5'd8 || out_data_o.bits_per_sample == 5'd16 ||
     out_data_o.bits_per_sample == 5'd24))
    else $error("accepted format out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_ERROR |-> out_data_o.error_code == ERR_NONE)
    else $error("error code on non-error word");

endmodule

bind wav_pcm_stream_parser_unit wpp_checker u_wpp_checker (.*);

// ----- dv/wav_pcm_stream_parser_unit_tb.sv -----
`timescale 1ns / 1ps

module wav_pcm_stream_parser_unit_tb;
  import wpp_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  wav_pcm_stream_parser_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // parser mirror
  logic [31:0] p_pos, p_window, p_fmt_off, p_data_off, p_rate, p_brate, p_left;
  logic [23:0] p_accum;
  logic [15:0] p_fmt_code, p_chans, p_align, p_depth;
  logic        p_fmt_found, p_chan;
  logic [1:0]  p_bis;
  phase_e      p_phase;

  out_t   pending_results[$];
  int     fail_count;
  int     hold_off;
  logic   gaps_on;
  byte    file_buf[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void parser_reset();
    p_pos = '0; p_window = '0; p_fmt_off = '0; p_fmt_found = 1'b0; p_data_off = '0;
    p_fmt_code = '0; p_chans = '0; p_rate = RATE_RESET; p_brate = '0; p_align = '0;
    p_depth = DEPTH_RESET; p_left = '0; p_accum = '0; p_bis = '0; p_chan = 1'b0;
    p_phase = PH_HEADER;
  endfunction

  function automatic out_t make_result(kind_e k, logic [23:0] s, logic c, err_e e);
    out_t r;
    r = '0;
    r.kind = k;
    r.sample_value = s;
    r.channel = c;
    r.error_code = e;
    if (k == KIND_FORMAT) begin
      r.num_channels = p_chans[1:0];
      r.rate_hz = p_rate;
      r.bits_per_sample = p_depth[4:0];
    end
    return r;
  endfunction

  function automatic void queue_result(out_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic logic [31:0] put_le(logic [31:0] old, logic [31:0] idx, logic [7:0] b);
    if (idx == 0) return {24'd0, b};
    return old | (32'(b) << (8 * idx[1:0]));
  endfunction

  // works out the results of one byte and queues them
  function automatic void predict_byte(logic [7:0] b, logic eof);
    int first;
    logic [31:0] pos, rel, bps, frame, v;
    logic [63:0] want_rate;
    err_e e;
    first = pending_results.size();
    pos = p_pos;
    if (p_pos != 32'hFFFF_FFFF) p_pos = p_pos + 1;
    case (p_phase)
      PH_HEADER: begin
        p_window = {p_window[23:0], b};
        if ((pos == 3 && p_window != TAG_RIFF) || (pos == 11 && p_window != TAG_WAVE)) begin
          queue_result(make_result(KIND_ERROR, '0, 0, ERR_CONTAINER));
          p_phase = PH_HALT;
        end else begin
          if (p_fmt_found) begin
            rel = pos - p_fmt_off;
            if (rel >= 8 && rel <= 23) begin
              if (rel < 10) p_fmt_code = 16'(put_le(32'(p_fmt_code), rel - 8, b));
              else if (rel < 12) p_chans = 16'(put_le(32'(p_chans), rel - 10, b));
              else if (rel < 16) p_rate = put_le(p_rate, rel - 12, b);
              else if (rel < 20) p_brate = put_le(p_brate, rel - 16, b);
              else if (rel < 22) p_align = 16'(put_le(32'(p_align), rel - 20, b));
              else p_depth = 16'(put_le(32'(p_depth), rel - 22, b));
            end
          end else if (pos >= 2 && p_window[23:0] == TAG_FMT) begin
            p_fmt_found = 1'b1;
            p_fmt_off = pos - 2;
          end
          if (eof) begin
            queue_result(make_result(KIND_ERROR, '0, 0, ERR_CONTAINER));
            p_phase = PH_HALT;
          end else if (pos >= 3 && p_window == TAG_DATA) begin
            p_data_off = pos - 3;
            if (!p_fmt_found || pos - p_fmt_off <= 23) begin
              queue_result(make_result(KIND_ERROR, '0, 0, ERR_ORDER));
              p_phase = PH_HALT;
            end else p_phase = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        rel = pos - p_data_off;
        if (rel >= 4 && rel <= 7) p_left = put_le(p_left, rel - 4, b);
        if (rel == 7) begin
          bps = 32'(p_depth) / 8;
          want_rate = (64'(p_chans) * 64'(p_rate) * 64'(p_depth)) / 8;
          e = ERR_NONE;
          if (p_fmt_code != 1) e = ERR_NOT_PCM;
          else if (p_chans < 1 || p_chans > 2) e = ERR_CHANNELS;
          else if (64'(p_brate) != want_rate || 32'(p_align) != 32'(p_chans) * bps)
            e = ERR_INCONSISTENT;
          else if (p_depth != 8 && p_depth != 16 && p_depth != 24) e = ERR_DEPTH;
          if (e != ERR_NONE) begin
            queue_result(make_result(KIND_ERROR, '0, 0, e));
            p_phase = PH_HALT;
          end else begin
            queue_result(make_result(KIND_FORMAT, '0, 0, ERR_NONE));
            frame = 32'(p_chans) * bps;
            p_left = p_left - (p_left % frame);
            if (p_left == 0 || eof) begin
              queue_result(make_result(KIND_END, '0, 0, ERR_NONE));
              p_phase = PH_HALT;
            end else begin
              p_phase = PH_SAMPLES;
              p_accum = '0; p_bis = '0; p_chan = 1'b0;
            end
          end
        end else if (eof) begin
          queue_result(make_result(KIND_ERROR, '0, 0, ERR_CONTAINER));
          p_phase = PH_HALT;
        end
      end
      PH_SAMPLES: begin
        bps = 32'(p_depth) / 8;
        p_accum = p_accum | 24'(32'(b) << (8 * p_bis));
        p_bis = p_bis + 1;
        p_left = p_left - 1;
        if (32'(p_bis) >= bps) begin
          if (bps == 1) v = {8'd0, p_accum[7:0] ^ 8'h80, 16'd0};
          else if (bps == 2) v = {8'd0, p_accum[15:0], 8'd0};
          else v = {8'd0, p_accum};
          queue_result(make_result(KIND_SAMPLE, v[23:0], p_chan, ERR_NONE));
          p_accum = '0; p_bis = '0;
          if (p_chans == 2) p_chan = ~p_chan;
        end
        if (p_left == 0 || eof) begin
          queue_result(make_result(KIND_END, '0, 0, ERR_NONE));
          p_phase = PH_HALT;
        end
      end
      default: ;
    endcase
    if (pending_results.size() > first)
      pending_results[pending_results.size() - 1].last_of_run = 1'b1;
    if (eof) parser_reset();
  endfunction

  // one word per handshake, with random gaps in between when enabled
  task automatic send_byte(logic [7:0] b, logic eof);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, end_of_file: eof};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b, eof);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_file_byte(logic [7:0] v);
    file_buf.insert(file_buf.size(), byte'(v));
  endtask

  task automatic push_le(int unsigned v, int n);
    for (int i = 0; i < n; i++) add_file_byte(8'(v >> (8 * i)));
  endtask

  task automatic push_tag(string s);
    for (int i = 0; i < 4; i++) add_file_byte(8'(s[i]));
  endtask

  // builds a header with given fields into file_buf
  task automatic build_header(int unsigned fmtc, int unsigned ch, int unsigned rate,
                              int unsigned depth, int unsigned size, logic consistent);
    int unsigned br, al;
    file_buf.delete();
    br = 32'((64'(ch) * 64'(rate) * 64'(depth)) / 8);
    al = ch * (depth / 8);
    if (!consistent) br = br + 1;
    push_tag("RIFF"); push_le($urandom, 4); push_tag("WAVE");
    if ($urandom_range(0, 2) == 0) begin
      push_tag("LIST"); push_le(4, 4); push_le($urandom & 32'h3f3f3f3f, 4);
    end
    push_tag("fmt "); push_le(16, 4);
    push_le(fmtc, 2); push_le(ch, 2); push_le(rate, 4); push_le(br, 4);
    push_le(al, 2); push_le(depth, 2);
    push_tag("data"); push_le(size, 4);
  endtask

  task automatic send_file(int unsigned extra);
    for (int i = 0; i < extra; i++) add_file_byte(8'($urandom));
    foreach (file_buf[i])
      send_byte(file_buf[i], (i == file_buf.size() - 1) ? 1'b1 : 1'b0);
  endtask

  task automatic test_directed();
    // pcm stereo 16 bit, whole frames plus a stray byte
    build_header(1, 2, 44100, 16, 9, 1'b1);
    add_file_byte(8'h00); add_file_byte(8'h80);
    add_file_byte(8'hff); add_file_byte(8'h7f);
    add_file_byte(8'h01); add_file_byte(8'h00);
    add_file_byte(8'hff); add_file_byte(8'hff);
    add_file_byte(8'h55); add_file_byte(8'haa);
    send_file(0);
    // bad riff
    file_buf.delete(); push_tag("RIFX"); send_file(2);
    // bad wave
    file_buf.delete(); push_tag("RIFF"); push_le(0, 4); push_tag("WAVX"); send_file(1);
    // data before fmt
    file_buf.delete(); push_tag("RIFF"); push_le(0, 4); push_tag("WAVE"); push_tag("data");
    send_file(1);
    // zero size, end on size byte
    build_header(1, 1, 8000, 8, 0, 1'b1); send_file(0);
  endtask

  task automatic test_errors();
    build_header(3, 1, 8000, 8, 4, 1'b1); send_file(0);
    build_header(1, 3, 8000, 8, 4, 1'b1); send_file(0);
    build_header(1, 1, 8000, 8, 4, 1'b0); send_file(0);
    build_header(1, 1, 8000, 12, 4, 1'b1); send_file(0);
    // eof in the header
    build_header(1, 1, 8000, 8, 4, 1'b1);
    file_buf = file_buf[0:20]; send_file(0);
    wait_drained();
  endtask

  task automatic test_random_files(int n_bytes);
    int sent;
    int unsigned ch, dep, sz, fmtc;
    int kind_pick;
    sent = 0;
    while (sent < n_bytes) begin
      ch = $urandom_range(1, 2);
      dep = 8 * $urandom_range(1, 3);
      sz = $urandom_range(0, 40);
      fmtc = 1;
      kind_pick = $urandom_range(0, 9);
      if (kind_pick == 0) fmtc = $urandom_range(0, 65535);
      build_header(fmtc, (kind_pick == 1) ? $urandom_range(0, 65535) : ch,
                   (kind_pick == 7) ? $urandom : $urandom_range(8000, 192000),
                   (kind_pick == 2) ? $urandom_range(0, 40) : dep,
                   (kind_pick == 3) ? $urandom : sz, kind_pick != 4);
      if (kind_pick == 5) file_buf[$urandom_range(0, file_buf.size() - 1)] = byte'($urandom);
      if (kind_pick == 6) file_buf = file_buf[0:$urandom_range(0, file_buf.size() - 1)];
      send_file((kind_pick == 6) ? 0 : $urandom_range(0, sz + 6));
      sent += file_buf.size();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 200;
    build_header(1, 2, 48000, 24, 60, 1'b1);
    send_file(60);
    wait_drained();
  endtask

  // receiver with its own stall pattern and a long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
        hold_off = hold_off - 1;
      end else if (!gaps_on) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $realtime, out_data_o);
          fail_count++;
        end else begin
          out_t w;
          w = pending_results.pop_front();
          if (w.kind != out_data_o.kind || w.sample_value != out_data_o.sample_value ||
              w.channel != out_data_o.channel || w.error_code != out_data_o.error_code ||
              w.num_channels != out_data_o.num_channels ||
              w.rate_hz != out_data_o.rate_hz ||
              w.bits_per_sample != out_data_o.bits_per_sample ||
              w.last_of_run != out_data_o.last_of_run) begin
            $display("%0t: mismatch, expected %p, actual %p", $realtime, w, out_data_o);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    hold_off = 0;
    gaps_on = 1'b0;
    parser_reset();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_errors();
    gaps_on = 1'b1;
    test_random_files(350);
    wait_drained();
    test_backpressure();
    gaps_on = 1'b0;
    test_random_files(150);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
